@@ hdl/bbvc_pkg.sv @@
// shared types and constants for the bounding box view cull pipeline
// no dependencies; imported by every module of the block
package bbvc_pkg;

   localparam int CoordWidth = 16;
   localparam int TrigWidth  = 10;
   localparam int ProdWidth  = CoordWidth + TrigWidth;

   localparam logic signed [CoordWidth-1:0] FrontClipPlane = 16'sd4;

   // which box edge a corner coordinate comes from
   typedef enum logic [1:0] {
      SIDE_TOP    = 2'd0,
      SIDE_BOTTOM = 2'd1,
      SIDE_LEFT   = 2'd2,
      SIDE_RIGHT  = 2'd3
   } side_type;

   typedef enum logic [1:0] {
      ZONE_LOW  = 2'd0,
      ZONE_MID  = 2'd1,
      ZONE_HIGH = 2'd2
   } zone_type;

   typedef struct packed {
      side_type ax;
      side_type ay;
      side_type bx;
      side_type by;
   } corner_sel_type;

   // indexed by {row, col}; entries with col == 3 cannot occur, center is inside
   localparam corner_sel_type CORNER_SEL [12] = '{
      '{SIDE_RIGHT, SIDE_TOP,    SIDE_LEFT,  SIDE_BOTTOM},
      '{SIDE_RIGHT, SIDE_TOP,    SIDE_LEFT,  SIDE_TOP},
      '{SIDE_RIGHT, SIDE_BOTTOM, SIDE_LEFT,  SIDE_TOP},
      '{SIDE_TOP,   SIDE_TOP,    SIDE_TOP,   SIDE_TOP},
      '{SIDE_LEFT,  SIDE_TOP,    SIDE_LEFT,  SIDE_BOTTOM},
      '{SIDE_TOP,   SIDE_TOP,    SIDE_TOP,   SIDE_TOP},
      '{SIDE_RIGHT, SIDE_BOTTOM, SIDE_RIGHT, SIDE_TOP},
      '{SIDE_TOP,   SIDE_TOP,    SIDE_TOP,   SIDE_TOP},
      '{SIDE_LEFT,  SIDE_TOP,    SIDE_RIGHT, SIDE_BOTTOM},
      '{SIDE_LEFT,  SIDE_BOTTOM, SIDE_RIGHT, SIDE_BOTTOM},
      '{SIDE_LEFT,  SIDE_BOTTOM, SIDE_RIGHT, SIDE_TOP},
      '{SIDE_TOP,   SIDE_TOP,    SIDE_TOP,   SIDE_TOP}
   };

   localparam int CfgViewX   = 0;
   localparam int CfgViewY   = 1;
   localparam int CfgViewSin = 2;
   localparam int CfgViewCos = 3;

   // control that travels with each beat
   typedef struct packed {
      logic valid;
      logic enclosed;
   } stage_ctl_type;

endpackage

@@ hdl/bbvc_select.sv @@
// stage 1: viewer region, silhouette corner pick, corners relative to viewer
// depends on bbvc_pkg
module bbvc_select
   import bbvc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [CoordWidth-1:0] box_top,
   input  logic signed [CoordWidth-1:0] box_bottom,
   input  logic signed [CoordWidth-1:0] box_left,
   input  logic signed [CoordWidth-1:0] box_right,
   input  logic signed [CoordWidth-1:0] view_x,
   input  logic signed [CoordWidth-1:0] view_y,
   output stage_ctl_type                ctl,
   output logic signed [CoordWidth-1:0] ax,
   output logic signed [CoordWidth-1:0] ay,
   output logic signed [CoordWidth-1:0] bx,
   output logic signed [CoordWidth-1:0] by
);

   zone_type                     col, row;
   corner_sel_type               sel;
   stage_ctl_type                ctl_ff, ctl_in;
   logic signed [CoordWidth-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [CoordWidth-1:0] ax_in, ay_in, bx_in, by_in;

   function automatic logic signed [CoordWidth-1:0] pick(
      input side_type                     side,
      input logic signed [CoordWidth-1:0] t,
      input logic signed [CoordWidth-1:0] b,
      input logic signed [CoordWidth-1:0] l,
      input logic signed [CoordWidth-1:0] r
   );
      logic signed [CoordWidth-1:0] v;
      case (side)
         SIDE_TOP:    v = t;
         SIDE_BOTTOM: v = b;
         SIDE_LEFT:   v = l;
         SIDE_RIGHT:  v = r;
         default:     v = t;
      endcase
      return v;
   endfunction

   always_comb begin
      if (view_x <= box_left) begin
         col = ZONE_LOW;
      end else if (view_x < box_right) begin
         col = ZONE_MID;
      end else begin
         col = ZONE_HIGH;
      end
      if (view_y >= box_top) begin
         row = ZONE_LOW;
      end else if (view_y > box_bottom) begin
         row = ZONE_MID;
      end else begin
         row = ZONE_HIGH;
      end
      sel = CORNER_SEL[{row, col}];

      // 16-bit wrap on the difference
      ax_in = pick(sel.ax, box_top, box_bottom, box_left, box_right) - view_x;
      ay_in = pick(sel.ay, box_top, box_bottom, box_left, box_right) - view_y;
      bx_in = pick(sel.bx, box_top, box_bottom, box_left, box_right) - view_x;
      by_in = pick(sel.by, box_top, box_bottom, box_left, box_right) - view_y;

      ctl_in.valid    = accept;
      ctl_in.enclosed = (row == ZONE_MID) && (col == ZONE_MID);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
   end

   assign ctl = ctl_ff;
   assign ax  = ax_ff;
   assign ay  = ay_ff;
   assign bx  = bx_ff;
   assign by  = by_ff;

endmodule

@@ hdl/bbvc_rotate.sv @@
// stages 2 and 3: eight products with sine and cosine, then truncated sums
// depends on bbvc_pkg
module bbvc_rotate
   import bbvc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  stage_ctl_type                ctl_i,
   input  logic signed [CoordWidth-1:0] ax,
   input  logic signed [CoordWidth-1:0] ay,
   input  logic signed [CoordWidth-1:0] bx,
   input  logic signed [CoordWidth-1:0] by,
   input  logic signed [TrigWidth-1:0]  view_sin,
   input  logic signed [TrigWidth-1:0]  view_cos,
   output stage_ctl_type                ctl_o,
   output logic signed [CoordWidth-1:0] ax_v,
   output logic signed [CoordWidth-1:0] ay_v,
   output logic signed [CoordWidth-1:0] bx_v,
   output logic signed [CoordWidth-1:0] by_v
);

   // only bits [23:8] of each shifted product reach the 16-bit sums
   localparam int Lo = 8;
   localparam int Hi = Lo + CoordWidth - 1;

   logic signed [ProdWidth-1:0]  ax_s, ay_c, bx_s, by_c, ax_c, ay_s, bx_c, by_s;
   logic        [CoordWidth-1:0] ax_s_ff, ay_c_ff, bx_s_ff, by_c_ff;
   logic        [CoordWidth-1:0] ax_c_ff, ay_s_ff, bx_c_ff, by_s_ff;
   stage_ctl_type                ctl2_ff, ctl3_ff;
   logic        [CoordWidth-1:0] ax_v_ff, ay_v_ff, bx_v_ff, by_v_ff;
   logic        [CoordWidth-1:0] ax_v_in, ay_v_in, bx_v_in, by_v_in;

   always_comb begin
      ax_s = ax * view_sin;
      ay_c = ay * view_cos;
      bx_s = bx * view_sin;
      by_c = by * view_cos;
      ax_c = ax * view_cos;
      ay_s = ay * view_sin;
      bx_c = bx * view_cos;
      by_s = by * view_sin;
   end

   always_comb begin
      ay_v_in = ax_s_ff + ay_c_ff;
      by_v_in = bx_s_ff + by_c_ff;
      ax_v_in = ax_c_ff - ay_s_ff;
      bx_v_in = bx_c_ff - by_s_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl2_ff <= ctl_i;
         ctl3_ff <= ctl2_ff;
      end
      ax_s_ff <= ax_s[Hi:Lo];
      ay_c_ff <= ay_c[Hi:Lo];
      bx_s_ff <= bx_s[Hi:Lo];
      by_c_ff <= by_c[Hi:Lo];
      ax_c_ff <= ax_c[Hi:Lo];
      ay_s_ff <= ay_s[Hi:Lo];
      bx_c_ff <= bx_c[Hi:Lo];
      by_s_ff <= by_s[Hi:Lo];
      ax_v_ff <= ax_v_in;
      ay_v_ff <= ay_v_in;
      bx_v_ff <= bx_v_in;
      by_v_ff <= by_v_in;
   end

   assign ctl_o = ctl3_ff;
   assign ax_v  = $signed(ax_v_ff);
   assign ay_v  = $signed(ay_v_ff);
   assign bx_v  = $signed(bx_v_ff);
   assign by_v  = $signed(by_v_ff);

endmodule

@@ hdl/bbvc_test.sv @@
// stage 4: near plane and field of view tests, registered result beat
// depends on bbvc_pkg
module bbvc_test
   import bbvc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  stage_ctl_type                ctl_i,
   input  logic signed [CoordWidth-1:0] ax_v,
   input  logic signed [CoordWidth-1:0] ay_v,
   input  logic signed [CoordWidth-1:0] bx_v,
   input  logic signed [CoordWidth-1:0] by_v,
   output logic                         valid,
   output logic                         visible
);

   logic signed [CoordWidth:0] a_sum, b_sum, a_dif, b_dif;
   logic                       behind, left_out, right_out;
   logic                       valid_ff, valid_in, visible_ff, visible_in;

   always_comb begin
      // 17 bits so that negating -32768 stays exact
      a_sum = $signed({ax_v[CoordWidth-1], ax_v}) + $signed({ay_v[CoordWidth-1], ay_v});
      b_sum = $signed({bx_v[CoordWidth-1], bx_v}) + $signed({by_v[CoordWidth-1], by_v});
      a_dif = $signed({ay_v[CoordWidth-1], ay_v}) - $signed({ax_v[CoordWidth-1], ax_v});
      b_dif = $signed({by_v[CoordWidth-1], by_v}) - $signed({bx_v[CoordWidth-1], bx_v});

      behind    = (ay_v < FrontClipPlane) && (by_v < FrontClipPlane);
      left_out  = a_sum[CoordWidth] && b_sum[CoordWidth];
      right_out = a_dif[CoordWidth] && b_dif[CoordWidth];

      valid_in   = ctl_i.valid;
      visible_in = ctl_i.enclosed || !(behind || left_out || right_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      visible_ff <= visible_in;
   end

   assign valid   = valid_ff;
   assign visible = visible_ff;

endmodule

@@ hdl/bounding_box_view_cull_unit.sv @@
// bounding box view cull: top level with view registers and the four-stage pipeline
// depends on bbvc_pkg, bbvc_select, bbvc_rotate, bbvc_test
//
// usage:
//   a box beat is taken on any clock edge with start high; busy is always low,
//   so a new box may be issued every cycle
//   the result beat is on rsp_maybe_visible with rsp_valid high for one cycle,
//   after the box has passed the select, product, sum and test registers in
//   that order; results leave in order
//   throughput is one box per clock, since every stage takes a new beat each cycle
//   (region and corner pick, products, sums, plane tests)
//   the receiver has no way to stall; it must take each result beat as shown
//   view registers are written through csr_we / csr_index / csr_wdata, one
//   register per cycle; the user must write them only while no box is in flight
//   (not enforced by the block); index order is view_x, view_y, view_sin, view_cos
//   reset clears the pipeline valids and loads view_x = 0, view_y = 0,
//   view_sin = 0, view_cos = 256; boxes may be issued on the next cycle
module bounding_box_view_cull_unit
   import bbvc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [CoordWidth-1:0] req_box_top,
   input  logic signed [CoordWidth-1:0] req_box_bottom,
   input  logic signed [CoordWidth-1:0] req_box_left,
   input  logic signed [CoordWidth-1:0] req_box_right,
   output logic                         rsp_valid,
   output logic                         rsp_maybe_visible,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [CoordWidth-1:0]        csr_wdata
);

   logic signed [CoordWidth-1:0] view_x_ff, view_y_ff;
   logic signed [TrigWidth-1:0]  view_sin_ff, view_cos_ff;
   stage_ctl_type                ctl1, ctl3;
   logic signed [CoordWidth-1:0] ax, ay, bx, by;
   logic signed [CoordWidth-1:0] ax_v, ay_v, bx_v, by_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_x_ff   <= '0;
         view_y_ff   <= '0;
         view_sin_ff <= '0;
         view_cos_ff <= 10'sd256;
      end else if (csr_we) begin
         case (csr_index)
            2'(CfgViewX):   view_x_ff   <= $signed(csr_wdata);
            2'(CfgViewY):   view_y_ff   <= $signed(csr_wdata);
            2'(CfgViewSin): view_sin_ff <= $signed(csr_wdata[TrigWidth-1:0]);
            2'(CfgViewCos): view_cos_ff <= $signed(csr_wdata[TrigWidth-1:0]);
            default: begin
            end
         endcase
      end
   end

   assign busy = 1'b0;

   bbvc_select u_select (
      .clock      (clock),
      .reset      (reset),
      .accept     (start && !busy),
      .box_top    (req_box_top),
      .box_bottom (req_box_bottom),
      .box_left   (req_box_left),
      .box_right  (req_box_right),
      .view_x     (view_x_ff),
      .view_y     (view_y_ff),
      .ctl        (ctl1),
      .ax         (ax),
      .ay         (ay),
      .bx         (bx),
      .by         (by)
   );

   bbvc_rotate u_rotate (
      .clock    (clock),
      .reset    (reset),
      .ctl_i    (ctl1),
      .ax       (ax),
      .ay       (ay),
      .bx       (bx),
      .by       (by),
      .view_sin (view_sin_ff),
      .view_cos (view_cos_ff),
      .ctl_o    (ctl3),
      .ax_v     (ax_v),
      .ay_v     (ay_v),
      .bx_v     (bx_v),
      .by_v     (by_v)
   );

   bbvc_test u_test (
      .clock   (clock),
      .reset   (reset),
      .ctl_i   (ctl3),
      .ax_v    (ax_v),
      .ay_v    (ay_v),
      .bx_v    (bx_v),
      .by_v    (by_v),
      .valid   (rsp_valid),
      .visible (rsp_maybe_visible)
   );

endmodule
